// ===== rtl/ccc_pkg.sv =====
package ccc_pkg;

    // Number of pipeline register stages from input to result
    localparam int NSTG = 19;

    // Contact offset search: one quotient bit per stage
    localparam int QBITS = 14;

    // Angle CORDIC: one micro-rotation per stage
    localparam int CORDIC_STEPS = 17;

    localparam logic [14:0] HALF_PI_Q13 = 15'd12868;

    // round(atan(2^-i) * 2^16)
    localparam logic [15:0] ATAN_TAB [CORDIC_STEPS] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047,
        16'd1024,  16'd512,   16'd256,   16'd128,  16'd64,   16'd32,
        16'd16,    16'd8,     16'd4,     16'd2,    16'd1
    };

    // Per-item side information that rides along with the pipeline
    typedef struct packed {
        logic [15:0] x1;
        logic [15:0] y1;
        logic        dx_pos;
        logic        dx_zero;
        logic        dy_pos;
        logic        dy_zero;
        logic        coll;
        logic        degen;
    } side_t;

    // Offset search state: p = t*t*s, t2s = t*s, with t = 2q-1
    typedef struct packed {
        logic [62:0]        p;
        logic signed [49:0] t2s;
        logic [QBITS-1:0]   q;
    } srch_t;

    // CORDIC vectoring state
    typedef struct packed {
        logic signed [35:0] x;
        logic signed [35:0] y;
        logic signed [19:0] z;
    } cord_t;

endpackage

// ===== rtl/circle_collision_contact.sv =====
// Circle-circle collision test with contact geometry. Each transfer on the pair
// channel carries two circles (centre, radius, Q12.4 / Q10.4) and a margin; each
// produces exactly one transfer on the result channel, in order. collided is set
// when the centre distance is at most r1 + r2 + margin (tested exactly on squares).
// On a collision the result gives the contact point on the first circle's rim
// toward the second (rounded to nearest, saturated to 17 bit signed Q13.4) and
// atan(dy/dx) of the centre difference in Q2.13 radians; coincident centres set
// degenerate, place the contact at the first centre and give angle zero. With no
// collision every result field is zero.
// Throughput is one item per clock while no finished result is held. The pipeline
// depth is set by the contact offset search (one quotient bit per stage, 14 stages,
// after the squaring and product stages), which runs beside a 17-stage CORDIC for
// the angle. The whole pipeline holds as one while a finished result waits:
// pair_stall is high exactly when result_valid is high and result_stall is high.
module circle_collision_contact (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               pair_valid,
    output logic               pair_stall,
    input  logic [15:0]        first_x,
    input  logic [15:0]        first_y,
    input  logic [13:0]        first_radius,
    input  logic [15:0]        second_x,
    input  logic [15:0]        second_y,
    input  logic [13:0]        second_radius,
    input  logic [11:0]        margin,

    output logic               result_valid,
    input  logic               result_stall,
    output logic               collided,
    output logic signed [16:0] contact_x,
    output logic signed [16:0] contact_y,
    output logic signed [14:0] contact_angle,
    output logic               degenerate
);

    localparam int NSTG  = ccc_pkg::NSTG;
    localparam int QBITS = ccc_pkg::QBITS;
    localparam int CSTEP = ccc_pkg::CORDIC_STEPS;

    // One search step: try setting quotient bit k, keep it if (2q-1)^2 * s <= lim.
    // The running products advance by shifts and adds only.
    function automatic ccc_pkg::srch_t srch_step(input ccc_pkg::srch_t cur,
                                                 input logic [32:0] s,
                                                 input logic [61:0] lim,
                                                 input int k);
        logic signed [67:0] cand;
        ccc_pkg::srch_t     nxt;
        cand = $signed({5'b0, cur.p})
             + ($signed(68'(cur.t2s)) <<< (k + 2))
             + ($signed({35'b0, s}) <<< (2 * k + 2));
        nxt = cur;
        if (cand <= $signed({6'b0, lim}))
        begin
            nxt.p   = cand[62:0];
            nxt.t2s = cur.t2s + ($signed({17'b0, s}) <<< (k + 1));
            nxt.q   = cur.q | (QBITS'(1) << k);
        end
        return nxt;
    endfunction

    // One CORDIC micro-rotation toward y = 0
    function automatic ccc_pkg::cord_t cord_step(input ccc_pkg::cord_t cur, input int i);
        logic signed [35:0] xs;
        logic signed [35:0] ys;
        ccc_pkg::cord_t     nxt;
        xs = cur.x >>> i;
        ys = cur.y >>> i;
        if (!cur.y[35])
        begin
            nxt.x = cur.x + ys;
            nxt.y = cur.y - xs;
            nxt.z = cur.z + $signed({4'b0, ccc_pkg::ATAN_TAB[i]});
        end
        else
        begin
            nxt.x = cur.x - ys;
            nxt.y = cur.y + xs;
            nxt.z = cur.z - $signed({4'b0, ccc_pkg::ATAN_TAB[i]});
        end
        return nxt;
    endfunction

    function automatic logic signed [16:0] sat17(input logic signed [17:0] v);
        logic signed [16:0] r;
        if (v > 18'sd65535)
            r = 17'sd65535;
        else if (v < -18'sd65536)
            r = -17'sd65536;
        else
            r = v[16:0];
        return r;
    endfunction

    // Whole pipeline advances unless a finished result is held
    logic adv;
    assign adv        = !(result_valid && result_stall);
    assign pair_stall = !adv;

    // Valid bits, one per stage
    logic vld_reg [1:NSTG];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int st = 1; st <= NSTG; st++)
                vld_reg[st] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[1] <= pair_valid;
            for (int st = 2; st <= NSTG; st++)
                vld_reg[st] <= vld_reg[st - 1];
        end
    end

    assign result_valid = vld_reg[NSTG];

    ccc_pkg::side_t side_reg [1:NSTG-1];

    // ---------------- Stage 1: differences, magnitudes, threshold
    logic [16:0] dx_next;
    logic [16:0] dy_next;
    logic [15:0] ax_next;
    logic [15:0] ay_next;
    logic [15:0] ax_reg;
    logic [15:0] ay_reg;
    logic [13:0] r1_reg;
    logic [15:0] thr_reg;

    always_comb
    begin
        dx_next = {1'b0, first_x} - {1'b0, second_x};
        dy_next = {1'b0, first_y} - {1'b0, second_y};
        ax_next = dx_next[16] ? 16'(-dx_next) : dx_next[15:0];
        ay_next = dy_next[16] ? 16'(-dy_next) : dy_next[15:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg            <= ax_next;
            ay_reg            <= ay_next;
            r1_reg            <= first_radius;
            thr_reg           <= {2'b0, first_radius} + {2'b0, second_radius}
                               + {4'b0, margin};
        end
    end

    // ---------------- Stage 2: squares
    logic [31:0] ax2_reg;
    logic [31:0] ay2_reg;
    logic [27:0] r1sq_reg;
    logic [31:0] thr2_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax2_reg  <= ax_reg * ax_reg;
            ay2_reg  <= ay_reg * ay_reg;
            r1sq_reg <= r1_reg * r1_reg;
            thr2_reg <= thr_reg * thr_reg;
        end
    end

    // ---------------- Stage 3: squared distance, squared offset numerators
    logic [32:0] s3_reg;
    logic [59:0] ax2r_reg;
    logic [59:0] ay2r_reg;
    logic [31:0] thr2b_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_reg    <= {1'b0, ax2_reg} + {1'b0, ay2_reg};
            ax2r_reg  <= ax2_reg * r1sq_reg;
            ay2r_reg  <= ay2_reg * r1sq_reg;
            thr2b_reg <= thr2_reg;
        end
    end

    // ---------------- Stage 4: collision and coincidence decisions
    logic [32:0] s4_reg;
    logic [61:0] limx4_reg;
    logic [61:0] limy4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_reg    <= s3_reg;
            limx4_reg <= {ax2r_reg, 2'b00};
            limy4_reg <= {ay2r_reg, 2'b00};
        end
    end

    ccc_pkg::side_t side4_next;

    always_comb
    begin
        side4_next       = side_reg[3];
        side4_next.coll  = (s3_reg <= {1'b0, thr2b_reg});
        side4_next.degen = (s3_reg == '0);
    end

    // Side band shift; stage 4 fills in the decisions
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[1].x1      <= first_x;
            side_reg[1].y1      <= first_y;
            side_reg[1].dx_pos  <= !dx_next[16] && (dx_next != '0);
            side_reg[1].dx_zero <= (dx_next == '0);
            side_reg[1].dy_pos  <= !dy_next[16] && (dy_next != '0);
            side_reg[1].dy_zero <= (dy_next == '0);
            side_reg[1].coll    <= 1'b0;
            side_reg[1].degen   <= 1'b0;
            for (int st = 2; st <= NSTG - 1; st++)
            begin
                if (st == 4)
                    side_reg[st] <= side4_next;
                else
                    side_reg[st] <= side_reg[st - 1];
            end
        end
    end

    // ---------------- Stages 5..18: offset search, MSB first
    ccc_pkg::srch_t srx_in  [0:QBITS-1];
    ccc_pkg::srch_t sry_in  [0:QBITS-1];
    logic [32:0]    s_in    [0:QBITS-1];
    logic [61:0]    limx_in [0:QBITS-1];
    logic [61:0]    limy_in [0:QBITS-1];
    ccc_pkg::srch_t srx_reg [0:QBITS-1];
    ccc_pkg::srch_t sry_reg [0:QBITS-1];
    logic [32:0]    sc_reg  [0:QBITS-2];
    logic [61:0]    lxc_reg [0:QBITS-2];
    logic [61:0]    lyc_reg [0:QBITS-2];

    for (genvar j = 0; j < QBITS; j++)
    begin : g_srch
        if (j == 0)
        begin : g_first
            // q = 0 means t = -1: p = s, t*s = -s
            always_comb
            begin
                srx_in[j].p   = {30'b0, s4_reg};
                srx_in[j].t2s = -$signed({17'b0, s4_reg});
                srx_in[j].q   = '0;
                sry_in[j]     = srx_in[j];
                s_in[j]       = s4_reg;
                limx_in[j]    = limx4_reg;
                limy_in[j]    = limy4_reg;
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                srx_in[j]  = srx_reg[j - 1];
                sry_in[j]  = sry_reg[j - 1];
                s_in[j]    = sc_reg[j - 1];
                limx_in[j] = lxc_reg[j - 1];
                limy_in[j] = lyc_reg[j - 1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                srx_reg[j] <= srch_step(srx_in[j], s_in[j], limx_in[j], QBITS - 1 - j);
                sry_reg[j] <= srch_step(sry_in[j], s_in[j], limy_in[j], QBITS - 1 - j);
            end
        end

        if (j < QBITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    sc_reg[j]  <= s_in[j];
                    lxc_reg[j] <= limx_in[j];
                    lyc_reg[j] <= limy_in[j];
                end
            end
        end
    end

    // ---------------- Stages 2..18: angle CORDIC on (|dx|, |dy|) * 2^16
    ccc_pkg::cord_t cord_in  [0:CSTEP-1];
    ccc_pkg::cord_t cord_reg [0:CSTEP-1];

    for (genvar c = 0; c < CSTEP; c++)
    begin : g_cord
        if (c == 0)
        begin : g_first
            always_comb
            begin
                cord_in[c].x = $signed({4'b0, ax_reg, 16'b0});
                cord_in[c].y = $signed({4'b0, ay_reg, 16'b0});
                cord_in[c].z = '0;
            end
        end
        else
        begin : g_rest
            assign cord_in[c] = cord_reg[c - 1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                cord_reg[c] <= cord_step(cord_in[c], c);
        end
    end

    // ---------------- Stage 19: rounding, saturation, result select
    ccc_pkg::side_t     sd;
    logic [QBITS-1:0]   qx;
    logic [QBITS-1:0]   qy;
    logic signed [19:0] zr;
    logic [14:0]        mag;
    logic signed [17:0] cx_sum;
    logic signed [17:0] cy_sum;
    logic               collided_next;
    logic signed [16:0] contact_x_next;
    logic signed [16:0] contact_y_next;
    logic signed [14:0] angle_next;
    logic               degenerate_next;

    always_comb
    begin
        sd = side_reg[NSTG - 1];
        qx = srx_reg[QBITS - 1].q;
        qy = sry_reg[QBITS - 1].q;

        // Q.16 to Q.13, round half up, clamp to 0..pi/2
        zr = (cord_reg[CSTEP - 1].z + 20'sd4) >>> 3;
        if (zr[19])
            mag = '0;
        else if (zr > $signed({5'b0, ccc_pkg::HALF_PI_Q13}))
            mag = ccc_pkg::HALF_PI_Q13;
        else
            mag = zr[14:0];

        // Step back from the first centre toward the second
        cx_sum = sd.dx_pos ? $signed({2'b0, sd.x1}) - $signed({4'b0, qx})
                           : $signed({2'b0, sd.x1}) + $signed({4'b0, qx});
        cy_sum = sd.dy_pos ? $signed({2'b0, sd.y1}) - $signed({4'b0, qy})
                           : $signed({2'b0, sd.y1}) + $signed({4'b0, qy});

        collided_next   = 1'b0;
        contact_x_next  = '0;
        contact_y_next  = '0;
        angle_next      = '0;
        degenerate_next = 1'b0;
        priority if (!sd.coll)
        begin
            collided_next = 1'b0;
        end
        else if (sd.degen)
        begin
            collided_next   = 1'b1;
            degenerate_next = 1'b1;
            contact_x_next  = $signed({1'b0, sd.x1});
            contact_y_next  = $signed({1'b0, sd.y1});
        end
        else
        begin
            collided_next  = 1'b1;
            contact_x_next = sat17(cx_sum);
            contact_y_next = sat17(cy_sum);
            priority if (sd.dx_zero)
                angle_next = sd.dy_pos ? $signed(ccc_pkg::HALF_PI_Q13)
                                       : -$signed(ccc_pkg::HALF_PI_Q13);
            else if (sd.dy_zero)
                angle_next = '0;
            else if (sd.dx_pos != sd.dy_pos)
                angle_next = -$signed(mag);
            else
                angle_next = $signed(mag);
        end
    end

    logic               collided_reg;
    logic signed [16:0] contact_x_reg;
    logic signed [16:0] contact_y_reg;
    logic signed [14:0] contact_angle_reg;
    logic               degenerate_reg;

    // Hold the result while it waits
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            collided_reg      <= collided_next;
            contact_x_reg     <= contact_x_next;
            contact_y_reg     <= contact_y_next;
            contact_angle_reg <= angle_next;
            degenerate_reg    <= degenerate_next;
        end
    end

    assign collided      = collided_reg;
    assign contact_x     = contact_x_reg;
    assign contact_y     = contact_y_reg;
    assign contact_angle = contact_angle_reg;
    assign degenerate    = degenerate_reg;

endmodule
